/* src/source_session_table_frame_sync_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the session table
// Shared wrappers that clock assertions on clk_i and disable them in reset.
// ----------------------------------------------------------------------------
`ifndef SOURCE_SESSION_TABLE_FRAME_SYNC_DEFINES_SVH
`define SOURCE_SESSION_TABLE_FRAME_SYNC_DEFINES_SVH

// Generic form with explicit clock and active-low reset.
`define SSTFS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Form used inside the block, on its own clock and reset.
`define SSTFS_CHECK(lbl, prop, msg) \
  `SSTFS_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

/* src/sstfs_pkg.sv */
// ----------------------------------------------------------------------------
// Session table package
// Widths, register indexes, reset values and the types shared by the cells.
// ----------------------------------------------------------------------------
package sstfs_pkg;

  localparam int SlotCountDef = 8;

  localparam int AddrW    = 32;
  localparam int ByteW    = 8;
  localparam int TimeW    = 32;
  localparam int PosW     = 6;
  localparam int LenW     = 7;
  localparam int ActW     = 4;
  localparam int SlotOutW = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;
  localparam int InDataW  = 72;
  localparam int OutDataW = 32;
  localparam int OutUsedW = 25;

  localparam logic [CfgIdxW-1:0] CFG_HDR_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HDR_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_LEN  = 2'd2;

  localparam logic [ByteW-1:0] HdrFirstRst  = 8'd87;
  localparam logic [ByteW-1:0] HdrSecondRst = 8'd84;
  localparam logic [LenW-1:0]  FrameLenRst  = 7'd54;
  localparam logic [LenW-1:0]  FrameLenMax  = 7'd64;
  localparam logic [ActW-1:0]  ActMax       = 4'd15;

  // Search item travelling down the cell chain.
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
    logic [TimeW-1:0] tstamp;
    logic             hit;
    logic [PosW-1:0]  hit_pos;
    logic             vac;
    logic [TimeW-1:0] old_time;
  } tok_t;

  // Write-back to the selected cell.
  typedef struct packed {
    logic             we;
    logic             take;
    logic [AddrW-1:0] addr;
    logic [TimeW-1:0] tstamp;
    logic [PosW-1:0]  pos;
  } upd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } state_e;

endpackage

/* src/source_session_table_frame_sync.sv */
// ----------------------------------------------------------------------------
// Source session table with frame sync
// Keys each byte by source address, picks or replaces a slot and tracks the
// two-byte header and the byte position of the frame in that slot.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   address, byte, time
// m_axis    out        m_axis_tvalid / m_axis_tready   slot and frame status
// cfg       in         cfg_we_i (no back-pressure)     header bytes, length
//
// Each item is loaded as the search item, passes through each cell of the
// slot chain in turn, and then its slot is picked and written back.
// The next item is accepted on the cycle after the write-back.
// Reset clears all slots and the active count; no clearing pass is needed.
// A stalled output holds the write-back until the output register is free;
// the output register lets the next item enter while a result waits.
// ----------------------------------------------------------------------------
`include "source_session_table_frame_sync_defines.svh"

module source_session_table_frame_sync #(
  parameter int SlotCount = sstfs_pkg::SlotCountDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // source_address[31:0], data_byte[39:32], time_ms[71:40]
  input  logic [sstfs_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // slot_index[2:0], new_session[3], evicted[4], byte_stored[5],
  // byte_position[11:6], byte_echo[19:12], frame_complete[20],
  // active_sessions[24:21], zero fill above
  output logic [sstfs_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [sstfs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sstfs_pkg::CfgDataW-1:0]  cfg_data_i
);
  import sstfs_pkg::*;

  localparam int IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  // Configuration registers.
  logic [ByteW-1:0] hdr1_q, hdr2_q;
  logic [LenW-1:0]  len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr1_q <= HdrFirstRst;
      hdr2_q <= HdrSecondRst;
      len_q  <= FrameLenRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HDR_FIRST:  hdr1_q <= cfg_data_i;
        CFG_HDR_SECOND: hdr2_q <= cfg_data_i;
        CFG_FRAME_LEN:  len_q  <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  state_e           state_q, state_d;
  tok_t             head_q, head_d;
  logic [ActW-1:0]  act_q, act_d;
  logic             out_vld_q, out_vld_d;
  logic [OutDataW-1:0] out_q, out_d;
  logic             accept, out_free, capture;
  upd_t             upd;

  // Registered decision, held until the write-back.
  logic [IdxW-1:0]  cm_slot_q;
  logic             cm_new_q, cm_evict_q, cm_stored_q, cm_done_q;
  logic [PosW-1:0]  cm_pos_q, cm_np_q;
  logic [ByteW-1:0] cm_byte_q;
  logic [AddrW-1:0] cm_addr_q;
  logic [TimeW-1:0] cm_time_q;

  // Slot chain.
  tok_t            tok     [SlotCount+1];
  logic [IdxW-1:0] hit_idx [SlotCount+1];
  logic [IdxW-1:0] vac_idx [SlotCount+1];
  logic [IdxW-1:0] old_idx [SlotCount+1];

  assign tok[0]     = head_q;
  assign hit_idx[0] = '0;
  assign vac_idx[0] = '0;
  assign old_idx[0] = '0;

  for (genvar g = 0; g < SlotCount; g++) begin : g_cell
    sstfs_cell #(
      .Index (g),
      .IdxW  (IdxW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok[g]),
      .hit_idx_i (hit_idx[g]),
      .vac_idx_i (vac_idx[g]),
      .old_idx_i (old_idx[g]),
      .tok_o     (tok[g+1]),
      .hit_idx_o (hit_idx[g+1]),
      .vac_idx_o (vac_idx[g+1]),
      .old_idx_o (old_idx[g+1]),
      .upd_i     (upd),
      .upd_idx_i (cm_slot_q)
    );
  end

  // Decision on the item leaving the last cell.
  tok_t             tl;
  logic [IdxW-1:0]  dc_slot;
  logic             dc_new, dc_evict, dc_stored, dc_done;
  logic [PosW-1:0]  dc_cur, dc_pos, dc_np;
  logic [LenW-1:0]  flen, nxt;

  assign tl   = tok[SlotCount];
  assign flen = (len_q > FrameLenMax) ? FrameLenMax : len_q;
  assign nxt  = {1'b0, dc_cur} + 7'd1;

  always_comb begin
    dc_slot   = old_idx[SlotCount];
    dc_new    = 1'b1;
    dc_evict  = 1'b1;
    dc_cur    = '0;
    if (tl.hit) begin
      dc_slot  = hit_idx[SlotCount];
      dc_new   = 1'b0;
      dc_evict = 1'b0;
      dc_cur   = tl.hit_pos;
    end else if (tl.vac) begin
      dc_slot  = vac_idx[SlotCount];
      dc_evict = 1'b0;
    end

    dc_stored = 1'b0;
    dc_pos    = '0;
    dc_done   = 1'b0;
    dc_np     = '0;
    if (dc_cur == '0) begin
      if (tl.data == hdr1_q) begin
        dc_stored = 1'b1;
        dc_np     = 6'd1;
      end
    end else if (dc_cur == 6'd1) begin
      // A wrong second byte restarts sync when it is itself a first header byte.
      if (tl.data == hdr2_q) begin
        dc_stored = 1'b1;
        dc_pos    = 6'd1;
        dc_np     = 6'd2;
      end else if (tl.data == hdr1_q) begin
        dc_stored = 1'b1;
        dc_np     = 6'd1;
      end
    end else begin
      dc_stored = 1'b1;
      dc_pos    = dc_cur;
      if (nxt >= flen) begin
        dc_done = 1'b1;
      end else begin
        dc_np = nxt[PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      cm_slot_q   <= dc_slot;
      cm_new_q    <= dc_new;
      cm_evict_q  <= dc_evict;
      cm_stored_q <= dc_stored;
      cm_done_q   <= dc_done;
      cm_pos_q    <= dc_pos;
      cm_np_q     <= dc_np;
      cm_byte_q   <= tl.data;
      cm_addr_q   <= tl.addr;
      cm_time_q   <= tl.tstamp;
    end
  end

  // Sequencer.
  logic [IdxW+2:0] slot_ext;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;
  assign slot_ext = {3'b000, cm_slot_q};

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    capture       = 1'b0;
    head_d        = '0;
    act_d         = act_q;
    out_vld_d     = out_vld_q && !m_axis_tready;
    out_d         = out_q;
    upd           = '0;
    upd.take      = cm_new_q;
    upd.addr      = cm_addr_q;
    upd.tstamp    = cm_time_q;
    upd.pos       = cm_np_q;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          head_d.valid  = 1'b1;
          head_d.addr   = s_axis_tdata[AddrW-1:0];
          head_d.data   = s_axis_tdata[AddrW+ByteW-1:AddrW];
          head_d.tstamp = s_axis_tdata[InDataW-1:AddrW+ByteW];
          state_d       = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tl.valid) begin
          capture = 1'b1;
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          if (cm_new_q && !cm_evict_q && (act_q != ActMax)) begin
            act_d = act_q + 4'd1;
          end
          upd.we    = 1'b1;
          out_vld_d = 1'b1;
          out_d     = {{(OutDataW-OutUsedW){1'b0}}, act_d, cm_done_q, cm_byte_q,
                       cm_pos_q, cm_stored_q, cm_evict_q, cm_new_q,
                       slot_ext[SlotOutW-1:0]};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      act_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      act_q     <= act_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // Checks.
  `SSTFS_CHECK(a_act_mono, act_q >= $past(act_q), "active count went down")
  `SSTFS_CHECK(a_evict_new, upd.we |-> (!cm_evict_q || cm_new_q), "eviction without new session")
  `SSTFS_CHECK(a_pos_zero, (upd.we && !cm_stored_q) |-> (cm_pos_q == '0), "position on dropped byte")
  `SSTFS_CHECK(a_chain_end, tl.valid |-> (state_q == ST_SEARCH), "search item left chain outside search")

endmodule

/* src/sstfs_cell.sv */
// ----------------------------------------------------------------------------
// Session table cell
// Holds one slot and folds it into the search item passing through.
// ----------------------------------------------------------------------------
module sstfs_cell #(
  parameter int Index = 0,
  parameter int IdxW  = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sstfs_pkg::tok_t   tok_i,
  input  logic [IdxW-1:0]   hit_idx_i,
  input  logic [IdxW-1:0]   vac_idx_i,
  input  logic [IdxW-1:0]   old_idx_i,
  output sstfs_pkg::tok_t   tok_o,
  output logic [IdxW-1:0]   hit_idx_o,
  output logic [IdxW-1:0]   vac_idx_o,
  output logic [IdxW-1:0]   old_idx_o,
  input  sstfs_pkg::upd_t   upd_i,
  input  logic [IdxW-1:0]   upd_idx_i
);
  import sstfs_pkg::*;

  localparam logic [IdxW-1:0] Me = IdxW'(Index);

  logic             valid_q;
  logic [PosW-1:0]  pos_q;
  logic [AddrW-1:0] addr_q;
  logic [TimeW-1:0] time_q;

  tok_t            tok_d, tok_q;
  logic [IdxW-1:0] hit_idx_d, hit_idx_q;
  logic [IdxW-1:0] vac_idx_d, vac_idx_q;
  logic [IdxW-1:0] old_idx_d, old_idx_q;
  logic            sel;

  assign sel = upd_i.we && (upd_idx_i == Me);

  always_comb begin
    tok_d     = tok_i;
    hit_idx_d = hit_idx_i;
    vac_idx_d = vac_idx_i;
    old_idx_d = old_idx_i;
    if (!tok_i.hit && valid_q && (addr_q == tok_i.addr)) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_pos = pos_q;
      hit_idx_d     = Me;
    end
    if (!tok_i.vac && !valid_q) begin
      tok_d.vac = 1'b1;
      vac_idx_d = Me;
    end
    // Strict compare keeps the lowest index on equal times.
    if (valid_q && ((Index == 0) || (time_q < tok_i.old_time))) begin
      tok_d.old_time = time_q;
      old_idx_d      = Me;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (sel) begin
        valid_q <= 1'b1;
        pos_q   <= upd_i.pos;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q <= hit_idx_d;
    vac_idx_q <= vac_idx_d;
    old_idx_q <= old_idx_d;
    if (sel) begin
      time_q <= upd_i.tstamp;
      if (upd_i.take) begin
        addr_q <= upd_i.addr;
      end
    end
  end

  assign tok_o     = tok_q;
  assign hit_idx_o = hit_idx_q;
  assign vac_idx_o = vac_idx_q;
  assign old_idx_o = old_idx_q;

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Session table with frame sync: stream-level testbench
// Drives address/byte/time items into the block with random gaps on both
// sides, predicts the slot choice, header sync and frame position of every
// item, and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sstfs_pkg::*;

  localparam int SLOTS       = SlotCountDef;
  localparam int POOL_SIZE   = 12;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYC  = SlotCountDef + 8;

  // Result fields, lowest bit last.
  typedef struct packed {
    logic [ActW-1:0]     active_sessions;
    logic                frame_complete;
    logic [ByteW-1:0]    byte_echo;
    logic [PosW-1:0]     byte_position;
    logic                byte_stored;
    logic                evicted;
    logic                new_session;
    logic [SlotOutW-1:0] slot_index;
  } frame_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // source_address[31:0], data_byte[39:32], time_ms[71:40]
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // slot_index[2:0], new_session[3], evicted[4], byte_stored[5],
  // byte_position[11:6], byte_echo[19:12], frame_complete[20],
  // active_sessions[24:21], zero fill above
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  source_session_table_frame_sync dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  // Predicted copy of the table and the registers.
  logic [ByteW-1:0] hdr_first  = HdrFirstRst;
  logic [ByteW-1:0] hdr_second = HdrSecondRst;
  logic [LenW-1:0]  frame_len  = FrameLenRst;
  logic             sess_valid [SLOTS] = '{default: 1'b0};
  logic [AddrW-1:0] sess_addr  [SLOTS] = '{default: '0};
  logic [TimeW-1:0] sess_time  [SLOTS] = '{default: '0};
  logic [PosW-1:0]  sess_pos   [SLOTS] = '{default: '0};
  logic [ActW-1:0]  active_cnt = '0;

  frame_result_t    pending_results [$];
  int               mismatches   = 0;
  int               result_count = 0;
  int               cycle_count  = 0;
  int               stall_left   = 0;
  bit               quiet        = 1'b0;
  logic [TimeW-1:0] clock_ms     = '0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none during a quiet stretch.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TimeW-1:0] next_stamp();
    if ($urandom_range(0, 9) == 0) return $urandom();
    clock_ms = clock_ms + $urandom_range(0, 2);
    return clock_ms;
  endfunction

  // Slot lookup, replacement and header sync for one accepted item.
  function automatic frame_result_t track_byte(logic [AddrW-1:0] addr,
                                               logic [ByteW-1:0] data,
                                               logic [TimeW-1:0] stamp);
    frame_result_t r;
    int            slot;
    logic [LenW-1:0] eff_len;
    logic [LenW-1:0] p;
    r = '0;
    slot = -1;
    eff_len = (frame_len > FrameLenMax) ? FrameLenMax : frame_len;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot < 0 && sess_valid[i] && sess_addr[i] == addr) slot = i;
    end
    if (slot < 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot < 0 && !sess_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        if (active_cnt != ActMax) active_cnt = active_cnt + 1'b1;
      end else begin
        slot = 0;
        for (int i = 1; i < SLOTS; i++) begin
          if (sess_time[i] < sess_time[slot]) slot = i;
        end
        r.evicted = 1'b1;
      end
      r.new_session    = 1'b1;
      sess_valid[slot] = 1'b1;
      sess_addr[slot]  = addr;
      sess_pos[slot]   = '0;
    end
    sess_time[slot] = stamp;
    p = LenW'(sess_pos[slot]);
    if (p == 0) begin
      if (data == hdr_first) begin
        r.byte_stored = 1'b1;
        p = 1;
      end
    end else if (p == 1) begin
      if (data == hdr_second) begin
        r.byte_stored   = 1'b1;
        r.byte_position = 1;
        p = 2;
      end else if (data == hdr_first) begin
        // A repeated first header byte restarts the sync.
        r.byte_stored = 1'b1;
        p = 1;
      end else begin
        p = 0;
      end
    end else begin
      r.byte_stored   = 1'b1;
      r.byte_position = p[PosW-1:0];
      p = p + 1'b1;
      // Lengths below three still end on the first byte after the header.
      if (p >= eff_len) begin
        p = 0;
        r.frame_complete = 1'b1;
      end
    end
    sess_pos[slot]    = p[PosW-1:0];
    r.slot_index      = SlotOutW'(slot);
    r.byte_echo       = data;
    r.active_sessions = active_cnt;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
             result_count, what, got, want);
    mismatches++;
  endtask

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else begin
      stall_left = idle_len();
      m_axis_tready = (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin : check_results
    frame_result_t got;
    frame_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[OutUsedW-1:0];
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", m_axis_tdata, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (got.slot_index !== want.slot_index)
          flag_mismatch("slot_index", got.slot_index, want.slot_index);
        if (got.new_session !== want.new_session)
          flag_mismatch("new_session", got.new_session, want.new_session);
        if (got.evicted !== want.evicted)
          flag_mismatch("evicted", got.evicted, want.evicted);
        if (got.byte_stored !== want.byte_stored)
          flag_mismatch("byte_stored", got.byte_stored, want.byte_stored);
        if (got.byte_position !== want.byte_position)
          flag_mismatch("byte_position", got.byte_position, want.byte_position);
        if (got.byte_echo !== want.byte_echo)
          flag_mismatch("byte_echo", got.byte_echo, want.byte_echo);
        if (got.frame_complete !== want.frame_complete)
          flag_mismatch("frame_complete", got.frame_complete, want.frame_complete);
        if (got.active_sessions !== want.active_sessions)
          flag_mismatch("active_sessions", got.active_sessions, want.active_sessions);
        if (m_axis_tdata[OutDataW-1:OutUsedW] !== '0)
          flag_mismatch("zero fill", m_axis_tdata[OutDataW-1:OutUsedW], 0);
      end
      result_count++;
    end
  end

  // Called and returns on a falling edge; valid stays high when the next
  // item follows without a gap.
  task automatic send_item(logic [AddrW-1:0] addr, logic [ByteW-1:0] data,
                           logic [TimeW-1:0] stamp);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {stamp, data, addr};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(track_byte(addr, data, stamp));
    @(negedge clk_i);
  endtask

  task automatic send_byte(logic [AddrW-1:0] addr, logic [ByteW-1:0] data);
    send_item(addr, data, next_stamp());
  endtask

  // Stop sending and wait until the block has drained.
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic apply_settings(logic [7:0] first, logic [7:0] second,
                                logic [7:0] len);
    settle();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = CFG_HDR_FIRST;
    cfg_data_i = first;
    @(negedge clk_i);
    cfg_idx_i  = CFG_HDR_SECOND;
    cfg_data_i = second;
    @(negedge clk_i);
    cfg_idx_i  = CFG_FRAME_LEN;
    cfg_data_i = len;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    hdr_first  = first;
    hdr_second = second;
    frame_len  = len[LenW-1:0];
  endtask

  // Mostly whole frames per source, some broken headers, some noise, over
  // more sources than slots so that replacement happens.
  task automatic run_traffic(int n_items);
    logic [AddrW-1:0] pool [POOL_SIZE];
    int               sent;
    int               kind;
    int               who;
    int               len;
    logic [ByteW-1:0] data;
    foreach (pool[i]) pool[i] = $urandom();
    clock_ms = $urandom_range(0, 1000);
    sent = 0;
    while (sent < n_items) begin
      quiet = ($urandom_range(0, 9) == 0);
      kind  = $urandom_range(0, 99);
      who   = $urandom_range(0, POOL_SIZE - 1);
      if (kind < 3) settle();
      if (kind < 65) begin
        len = (frame_len > FrameLenMax) ? FrameLenMax :
              (frame_len < 3) ? 3 : frame_len;
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_byte(pool[$urandom_range(0, POOL_SIZE - 1)], $urandom_range(0, 255));
            sent++;
          end
          data = (k == 0) ? hdr_first : (k == 1) ? hdr_second : $urandom_range(0, 255);
          send_byte(pool[who], data);
          sent++;
        end
      end else if (kind < 85) begin
        send_byte(pool[who], hdr_first);
        send_byte(pool[who], $urandom_range(0, 1) ? hdr_first : $urandom_range(0, 255));
        send_byte(pool[who], $urandom_range(0, 1) ? hdr_second : $urandom_range(0, 255));
        sent += 3;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(($urandom_range(0, 2) == 0) ? $urandom() :
                    pool[$urandom_range(0, POOL_SIZE - 1)], $urandom_range(0, 255));
          sent++;
        end
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_item(32'h0000_0000, HdrFirstRst, 32'h0000_0000);
    send_item(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(32'h0000_0000, HdrSecondRst, 32'h0000_0000);
    send_item(32'h0000_0000, 8'h00, 32'h0000_0000);
  endtask

  task automatic test_header_sync();
    logic [AddrW-1:0] src;
    src = 32'h5A5A_A5A5;
    apply_settings(8'h00, 8'hFF, 8'd3);
    send_item(src, 8'hFF, 32'd1000);
    send_item(src, 8'h00, 32'd1000);
    send_item(src, 8'h00, 32'd1000);
    send_item(src, 8'h34, 32'd1000);
    send_item(src, 8'h00, 32'd1000);
    send_item(src, 8'hFF, 32'd1000);
    send_item(src, 8'hAB, 32'd1000);
  endtask

  // Fill the remaining slots with equal old stamps, then force replacements.
  task automatic test_oldest_replacement();
    for (int i = 1; i <= 5; i++) send_item(32'h0A00_0000 + i, 8'h00, 32'd0);
    send_item(32'hC0A8_0101, 8'h00, 32'd7);
    send_item(32'hC0A8_0102, 8'h5C, 32'd9);
    send_item(32'h0000_0000, 8'h00, 32'd12);
  endtask

  task automatic test_length_extremes();
    apply_settings(8'hFF, 8'h00, 8'd64);
    run_traffic(130);
    apply_settings($urandom_range(0, 255), $urandom_range(0, 255), 8'hFF);
    run_traffic(70);
    apply_settings($urandom_range(0, 255), $urandom_range(0, 255), 8'd0);
    run_traffic(50);
  endtask

  task automatic test_random_settings();
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] len;
    for (int ph = 0; ph < 5; ph++) begin
      first  = $urandom_range(0, 255);
      second = (ph == 1) ? first : $urandom_range(0, 255);
      len    = {1'($urandom_range(0, 1)), 7'($urandom_range(3, 12))};
      apply_settings(first, second, len);
      run_traffic(70);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_header_sync();
    test_oldest_replacement();
    test_length_extremes();
    test_random_settings();
    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
